>>> rtl/nsv_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence validator package
// Shared constants, codes, types and the hex digit decoder.
// ----------------------------------------------------------------------------
package nsv_pkg;

    localparam int MAX_SENTENCE = 128;
    localparam int TALKER_LEN   = 2;
    localparam int TYPE_LEN     = 3;
    localparam int POS_W        = $clog2(MAX_SENTENCE + 1);

    localparam int CHAR_W  = 8;
    localparam int NAME_W  = 24;
    localparam int CODE_W  = 2;
    localparam int STAT_W  = 3;
    localparam int INDEX_W = 2;

    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'd36;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'd42;
    localparam logic [CHAR_W-1:0] CH_0      = 8'd48;
    localparam logic [CHAR_W-1:0] CH_9      = 8'd57;
    localparam logic [CHAR_W-1:0] CH_LC_A   = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LC_F   = 8'd102;
    localparam logic [CHAR_W-1:0] CH_UC_A   = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UC_F   = 8'd70;
    localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'd48;
    localparam logic [CHAR_W-1:0] OFS_LC    = 8'd87;
    localparam logic [CHAR_W-1:0] OFS_UC    = 8'd55;

    localparam logic [NAME_W-1:0] NAME_GLL = 24'h474C4C;
    localparam logic [NAME_W-1:0] NAME_GSA = 24'h475341;
    localparam logic [NAME_W-1:0] NAME_ZDA = 24'h5A4441;

    localparam logic [INDEX_W-1:0] CFG_FIRST  = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_SECOND = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_THIRD  = 2'd2;

    localparam logic [CODE_W-1:0] TYPE_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] TYPE_FIRST  = 2'd1;
    localparam logic [CODE_W-1:0] TYPE_SECOND = 2'd2;
    localparam logic [CODE_W-1:0] TYPE_THIRD  = 2'd3;

    localparam logic [STAT_W-1:0] ST_VALID    = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADHEX   = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERLONG = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HEX1 = 4'b0100,
        PH_HEX2 = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [NAME_W-1:0] first;
        logic [NAME_W-1:0] second;
        logic [NAME_W-1:0] third;
    } t_type_names;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] sentence_type;
        logic [STAT_W-1:0] status;
        logic [CHAR_W-1:0] checksum;
    } t_result;

    typedef struct packed {
        logic       bad;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(input logic [CHAR_W-1:0] ch);
        t_hex             h;
        logic [CHAR_W-1:0] d;
        d     = '0;
        h.bad = 1'b0;
        if (ch >= CH_0 && ch <= CH_9) begin
            d = ch - OFS_DIGIT;
        end else if (ch >= CH_LC_A && ch <= CH_LC_F) begin
            d = ch - OFS_LC;
        end else if (ch >= CH_UC_A && ch <= CH_UC_F) begin
            d = ch - OFS_UC;
        end else begin
            h.bad = 1'b1;
        end
        h.nib = d[3:0];
        return h;
    endfunction

endpackage

>>> rtl/nmea_sentence_validator_core.sv
// ----------------------------------------------------------------------------
// NMEA sentence validator core
// Checks NMEA 0183 sentences character by character and reports type and
// checksum status once per sentence.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle with no gaps while the result side
// keeps up: each character is registered in the input register, the parser
// forms its result combinationally as it updates its state, and any result
// lands in the output register, from which it is presented. While a result
// is held by a stalled receiver, the character in the input register waits
// and intake stops until that result is taken, whether or not the waiting
// character gives a result.
// ----------------------------------------------------------------------------
module nmea_sentence_validator_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [nsv_pkg::INDEX_W-1:0]  i_cfg_index,
    input  logic [nsv_pkg::NAME_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [nsv_pkg::CHAR_W-1:0]   i_rx_char,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [nsv_pkg::CODE_W-1:0]   o_sentence_type,
    output logic [nsv_pkg::STAT_W-1:0]   o_status,
    output logic [nsv_pkg::CHAR_W-1:0]   o_computed_checksum
);

    nsv_pkg::t_type_names        r_names;
    logic                        r_in_valid;
    logic [nsv_pkg::CHAR_W-1:0]  r_in_char;
    logic                        r_out_valid;
    logic [nsv_pkg::CODE_W-1:0]  r_out_type;
    logic [nsv_pkg::STAT_W-1:0]  r_out_status;
    logic [nsv_pkg::CHAR_W-1:0]  r_out_sum;
    logic                        advance;
    logic                        in_accept;
    logic [nsv_pkg::NAME_W-1:0]  captured;
    logic [nsv_pkg::CODE_W-1:0]  match;
    nsv_pkg::t_result            result;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_names.first  <= nsv_pkg::NAME_GLL;
            r_names.second <= nsv_pkg::NAME_GSA;
            r_names.third  <= nsv_pkg::NAME_ZDA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nsv_pkg::CFG_FIRST:  r_names.first  <= i_cfg_data;
                nsv_pkg::CFG_SECOND: r_names.second <= i_cfg_data;
                nsv_pkg::CFG_THIRD:  r_names.third  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold the item until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_char <= i_rx_char;
        end
    end

    nsv_type_match u_match (
        .i_captured (captured),
        .i_names    (r_names),
        .o_code     (match)
    );

    nsv_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_char     (r_in_char),
        .i_match    (match),
        .o_captured (captured),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_type   <= result.sentence_type;
            r_out_status <= result.status;
            r_out_sum    <= result.checksum;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_sentence_type     = r_out_type;
    assign o_status            = r_out_status;
    assign o_computed_checksum = r_out_sum;

endmodule

>>> rtl/nsv_type_match.sv
// ----------------------------------------------------------------------------
// NMEA sentence type matcher
// Compares the captured type against the three programmed names, first,
// third, then second, and returns the code of the first match.
// ----------------------------------------------------------------------------
module nsv_type_match (
    input  logic [nsv_pkg::NAME_W-1:0] i_captured,
    input  nsv_pkg::t_type_names       i_names,
    output logic [nsv_pkg::CODE_W-1:0] o_code
);

    always_comb begin
        if (i_captured == i_names.first) begin
            o_code = nsv_pkg::TYPE_FIRST;
        end else if (i_captured == i_names.third) begin
            o_code = nsv_pkg::TYPE_THIRD;
        end else if (i_captured == i_names.second) begin
            o_code = nsv_pkg::TYPE_SECOND;
        end else begin
            o_code = nsv_pkg::TYPE_NONE;
        end
    end

endmodule

>>> rtl/nsv_parser.sv
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Tracks the sentence phase, running XOR, type capture and hex checksum for
// one character per enabled cycle, and forms the result for that character.
// ----------------------------------------------------------------------------
module nsv_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [nsv_pkg::CHAR_W-1:0] i_char,
    input  logic [nsv_pkg::CODE_W-1:0] i_match,
    output logic [nsv_pkg::NAME_W-1:0] o_captured,
    output nsv_pkg::t_result           o_result
);

    nsv_pkg::t_phase             r_phase, n_phase;
    logic [nsv_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [nsv_pkg::CHAR_W-1:0]  r_xor, n_xor;
    logic [nsv_pkg::NAME_W-1:0]  r_cap, n_cap;
    logic [3:0]                  r_hi, n_hi;
    logic                        r_fault, n_fault;
    nsv_pkg::t_hex               hex;
    logic                        type_known;
    logic [nsv_pkg::CHAR_W-1:0]  received;

    assign o_captured = r_cap;
    assign hex        = nsv_pkg::hex_decode(i_char);
    assign type_known = (r_pos >= nsv_pkg::POS_W'(nsv_pkg::TALKER_LEN + nsv_pkg::TYPE_LEN))
                        && (i_match != nsv_pkg::TYPE_NONE);
    assign received   = {r_hi, hex.nib};

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_cap    = r_cap;
        n_hi     = r_hi;
        n_fault  = r_fault;
        o_result = '0;
        if (i_char == nsv_pkg::CH_DOLLAR) begin
            n_phase = nsv_pkg::PH_BODY;
            n_pos   = '0;
            n_xor   = '0;
            n_cap   = '0;
            n_hi    = '0;
            n_fault = 1'b0;
        end else begin
            unique case (r_phase)
                nsv_pkg::PH_BODY: begin
                    if (i_char == nsv_pkg::CH_STAR) begin
                        n_phase = nsv_pkg::PH_HEX1;
                    end else if (r_pos >= nsv_pkg::POS_W'(nsv_pkg::MAX_SENTENCE)) begin
                        o_result.valid         = 1'b1;
                        o_result.sentence_type = nsv_pkg::TYPE_NONE;
                        o_result.status        = nsv_pkg::ST_OVERLONG;
                        o_result.checksum      = r_xor;
                        n_phase                = nsv_pkg::PH_IDLE;
                    end else begin
                        n_xor = r_xor ^ i_char;
                        if (r_pos >= nsv_pkg::POS_W'(nsv_pkg::TALKER_LEN) &&
                            r_pos < nsv_pkg::POS_W'(nsv_pkg::TALKER_LEN + nsv_pkg::TYPE_LEN)) begin
                            n_cap = {r_cap[nsv_pkg::NAME_W-nsv_pkg::CHAR_W-1:0], i_char};
                        end
                        n_pos = r_pos + 1'b1;
                    end
                end
                nsv_pkg::PH_HEX1: begin
                    n_hi    = hex.nib;
                    n_fault = hex.bad;
                    n_phase = nsv_pkg::PH_HEX2;
                end
                nsv_pkg::PH_HEX2: begin
                    n_phase           = nsv_pkg::PH_IDLE;
                    o_result.valid    = 1'b1;
                    o_result.checksum = r_xor;
                    if (!type_known) begin
                        o_result.sentence_type = nsv_pkg::TYPE_NONE;
                        o_result.status        = nsv_pkg::ST_UNKNOWN;
                    end else if (r_fault || hex.bad) begin
                        o_result.sentence_type = i_match;
                        o_result.status        = nsv_pkg::ST_BADHEX;
                    end else if (received != r_xor) begin
                        o_result.sentence_type = i_match;
                        o_result.status        = nsv_pkg::ST_MISMATCH;
                    end else begin
                        o_result.sentence_type = i_match;
                        o_result.status        = nsv_pkg::ST_VALID;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nsv_pkg::PH_IDLE;
            r_pos   <= '0;
            r_xor   <= '0;
            r_cap   <= '0;
            r_hi    <= '0;
            r_fault <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_xor   <= n_xor;
            r_cap   <= n_cap;
            r_hi    <= n_hi;
            r_fault <= n_fault;
        end
    end

endmodule
